FILE: src/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and constants for the source tokenizer: the scan modes, the
// token kinds, the character codes and the layout of one token descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

	// Scan modes of the lexer. The modes EQ through SLASH hold one character
	// of lookahead.
	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_LINE  = 4'd1,
		M_BLOCK = 4'd2,
		M_STR   = 4'd3,
		M_NUM   = 4'd4,
		M_IDENT = 4'd5,
		M_EQ    = 4'd6,
		M_BANG  = 4'd7,
		M_PLUS  = 4'd8,
		M_MINUS = 4'd9,
		M_SLASH = 4'd10
	} mode_t;

	// Token kinds as they appear on the result channel.
	typedef enum logic [4:0] {
		K_EOF     = 5'd0,
		K_SEMI    = 5'd1,
		K_LBRACE  = 5'd2,
		K_RBRACE  = 5'd3,
		K_LPAREN  = 5'd4,
		K_RPAREN  = 5'd5,
		K_EQEQ    = 5'd6,
		K_ASSIGN  = 5'd7,
		K_NOTEQ   = 5'd8,
		K_LESS    = 5'd9,
		K_GREATER = 5'd10,
		K_INC     = 5'd11,
		K_DEC     = 5'd12,
		K_STRING  = 5'd13,
		K_NUMBER  = 5'd14,
		K_IDENT   = 5'd15,
		K_UNKNOWN = 5'd16
	} kind_t;

	// Character codes.
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	// Width of the position and length fields on the result channel.
	localparam int unsigned FIELD_BITS = 16;

	// One token descriptor as it is buffered for the result channel.
	typedef struct packed {
		kind_t                   kind;
		logic [FIELD_BITS-1:0]   line;
		logic [FIELD_BITS-1:0]   column;
		logic [FIELD_BITS-1:0]   length;
		logic                    last;
	} token_t;

	function automatic token_t make_token(input kind_t k, input logic [FIELD_BITS-1:0] ln,
			input logic [FIELD_BITS-1:0] col, input logic [FIELD_BITS-1:0] len);
		token_t t;
		t.kind   = k;
		t.line   = ln;
		t.column = col;
		t.length = len;
		t.last   = 1'b0;
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
			((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
	endfunction

endpackage

`default_nettype wire

FILE: src/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: takes one source byte per transaction and emits token
// descriptors (kind, start line, start column, value length).
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                           Contents
//  -------  ---------  --------------------------------  ----------------------------
//  s_*      in         s_tvalid s_tready s_tdata s_tlast  source byte, end of input
//  m_*      out        m_tvalid m_tready m_tdata m_tuser  token kind, line, column,
//                      m_tlast                            length, last of the byte
//
// One byte transaction is accepted per cycle while s_tready is high. Once its byte
// is registered, the scanner decodes it and writes up to two descriptors into a
// four-entry result buffer, from which the tokens are read on the m_* channel.
// The scanner runs only while the buffer has room for two descriptors; under an
// output stall s_tready falls once the input register also holds a byte.
// Reset is asynchronous: line 1, column 1, between tokens, buffers empty.
//
`default_nettype none

module source_tokenizer #(
	parameter int unsigned POSITION_BITS = 16,
	parameter int unsigned LENGTH_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] source_byte
	input  wire logic        s_tlast,   // input_ends

	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [47:0] m_tdata,   // [15:0] start_line, [31:16] start_column,
	                                    // [47:32] value_length
	output      logic [7:0]  m_tuser,   // [4:0] token_kind, [7:5] zero
	output      logic        m_tlast    // last_of_run
);

	localparam int unsigned FB         = stok_pkg::FIELD_BITS;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
	localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0]   LEN_TWO = LENGTH_BITS'(2);

	// ------------------------------------------------------------------
	// Input register stage.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ends_s1;
	logic       process;

	// ------------------------------------------------------------------
	// Scanner state.
	// ------------------------------------------------------------------
	stok_pkg::mode_t            mode_q;
	logic [POSITION_BITS-1:0]   line_q;
	logic [POSITION_BITS-1:0]   col_q;
	logic [POSITION_BITS-1:0]   tok_line_q;
	logic [POSITION_BITS-1:0]   tok_col_q;
	logic [LENGTH_BITS-1:0]     tok_len_q;
	logic                       saw_star_q;

	stok_pkg::mode_t            mode_d;
	logic [POSITION_BITS-1:0]   line_d;
	logic [POSITION_BITS-1:0]   col_d;
	logic [POSITION_BITS-1:0]   tok_line_d;
	logic [POSITION_BITS-1:0]   tok_col_d;
	logic [LENGTH_BITS-1:0]     tok_len_d;
	logic                       saw_star_d;

	stok_pkg::token_t           res [2];
	logic [1:0]                 n_res;
	logic                       again;

	// ------------------------------------------------------------------
	// Result buffer.
	// ------------------------------------------------------------------
	stok_pkg::token_t           fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]        wr_ptr_q;
	logic [PTR_BITS-1:0]        rd_ptr_q;
	logic [PTR_BITS:0]          count_q;
	logic [1:0]                 push_cnt;
	logic                       pop;

	// The scanner needs room for the worst case of two descriptors.
	assign process  = valid_s1 && (count_q <= (PTR_BITS+1)'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || process;
	assign push_cnt = process ? n_res : 2'd0;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			ends_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Scanner: decode the registered byte against the current mode.
	// ------------------------------------------------------------------
	always_comb begin
		mode_d     = mode_q;
		line_d     = line_q;
		col_d      = col_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		tok_len_d  = tok_len_q;
		saw_star_d = saw_star_q;
		res[0]     = '0;
		res[1]     = '0;
		n_res      = 2'd0;
		again      = 1'b0;

		if (ends_s1) begin
			// End of input: flush whatever token is still open, then Eof.
			case (mode_q)
				stok_pkg::M_STR: begin
					res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
						FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
					n_res = n_res + 2'd1;
				end
				stok_pkg::M_NUM: begin
					res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_NUMBER,
						FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
					n_res = n_res + 2'd1;
				end
				stok_pkg::M_IDENT: begin
					res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_IDENT,
						FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
					n_res = n_res + 2'd1;
				end
				stok_pkg::M_EQ: begin
					res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_ASSIGN,
						FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
					n_res = n_res + 2'd1;
				end
				stok_pkg::M_BANG, stok_pkg::M_PLUS, stok_pkg::M_MINUS,
				stok_pkg::M_SLASH: begin
					res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
						FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
					n_res = n_res + 2'd1;
				end
				default: begin
				end
			endcase
			res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_EOF,
				FB'(line_q), FB'(col_q), '0);
			n_res      = n_res + 2'd1;
			mode_d     = stok_pkg::M_IDLE;
			line_d     = POS_ONE;
			col_d      = POS_ONE;
			tok_line_d = POS_ONE;
			tok_col_d  = POS_ONE;
			tok_len_d  = '0;
			saw_star_d = 1'b0;
		end else begin
			case (mode_q)
				stok_pkg::M_LINE: begin
					if (byte_s1 == stok_pkg::CH_LF) begin
						mode_d = stok_pkg::M_IDLE;
					end
				end
				stok_pkg::M_BLOCK: begin
					if (saw_star_q && byte_s1 == stok_pkg::CH_SLASH) begin
						mode_d     = stok_pkg::M_IDLE;
						saw_star_d = 1'b0;
					end else begin
						saw_star_d = (byte_s1 == stok_pkg::CH_STAR);
					end
				end
				stok_pkg::M_STR: begin
					if (byte_s1 == stok_pkg::CH_QUOTE) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_STRING,
							FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
						n_res  = n_res + 2'd1;
						mode_d = stok_pkg::M_IDLE;
					end else if (byte_s1 == stok_pkg::CH_LF) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end else if (tok_len_q != LEN_MAX) begin
						tok_len_d = tok_len_q + LEN_ONE;
					end
				end
				stok_pkg::M_NUM: begin
					if (stok_pkg::is_digit(byte_s1)) begin
						if (tok_len_q != LEN_MAX) begin
							tok_len_d = tok_len_q + LEN_ONE;
						end
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_NUMBER,
							FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_IDENT: begin
					if (stok_pkg::is_digit(byte_s1) || stok_pkg::is_alpha(byte_s1) ||
							byte_s1 == stok_pkg::CH_UNDER) begin
						if (tok_len_q != LEN_MAX) begin
							tok_len_d = tok_len_q + LEN_ONE;
						end
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_IDENT,
							FB'(tok_line_q), FB'(tok_col_q), FB'(tok_len_q));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_EQ: begin
					if (byte_s1 == stok_pkg::CH_EQUAL) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_EQEQ,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_TWO));
						n_res  = n_res + 2'd1;
						mode_d = stok_pkg::M_IDLE;
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_ASSIGN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_BANG: begin
					if (byte_s1 == stok_pkg::CH_EQUAL) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_NOTEQ,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_TWO));
						n_res  = n_res + 2'd1;
						mode_d = stok_pkg::M_IDLE;
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_PLUS: begin
					if (byte_s1 == stok_pkg::CH_PLUS) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_INC,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_TWO));
						n_res  = n_res + 2'd1;
						mode_d = stok_pkg::M_IDLE;
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_MINUS: begin
					if (byte_s1 == stok_pkg::CH_MINUS) begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_DEC,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_TWO));
						n_res  = n_res + 2'd1;
						mode_d = stok_pkg::M_IDLE;
					end else if (stok_pkg::is_digit(byte_s1)) begin
						// A minus sign followed by a digit opens a negative number.
						mode_d    = stok_pkg::M_NUM;
						tok_len_d = LEN_TWO;
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				stok_pkg::M_SLASH: begin
					if (byte_s1 == stok_pkg::CH_SLASH) begin
						mode_d = stok_pkg::M_LINE;
					end else if (byte_s1 == stok_pkg::CH_STAR) begin
						mode_d     = stok_pkg::M_BLOCK;
						saw_star_d = 1'b0;
					end else begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
							FB'(tok_line_q), FB'(tok_col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
						again = 1'b1;
					end
				end
				default: begin
					again = 1'b1;
				end
			endcase

			// The byte was not consumed by an open token: it starts a new one
			// at the current position.
			if (again) begin
				tok_line_d = line_q;
				tok_col_d  = col_q;
				tok_len_d  = '0;
				mode_d     = stok_pkg::M_IDLE;
				case (byte_s1)
					stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_LF,
					stok_pkg::CH_CR: begin
					end
					stok_pkg::CH_SEMI: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_SEMI,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_LBRACE: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_LBRACE,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_RBRACE: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_RBRACE,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_LPAREN: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_LPAREN,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_RPAREN: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_RPAREN,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_LESS: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_LESS,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_GREATER: begin
						res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_GREATER,
							FB'(line_q), FB'(col_q), FB'(LEN_ONE));
						n_res = n_res + 2'd1;
					end
					stok_pkg::CH_EQUAL: mode_d = stok_pkg::M_EQ;
					stok_pkg::CH_BANG:  mode_d = stok_pkg::M_BANG;
					stok_pkg::CH_PLUS:  mode_d = stok_pkg::M_PLUS;
					stok_pkg::CH_MINUS: mode_d = stok_pkg::M_MINUS;
					stok_pkg::CH_SLASH: mode_d = stok_pkg::M_SLASH;
					stok_pkg::CH_QUOTE: mode_d = stok_pkg::M_STR;
					default: begin
						if (stok_pkg::is_digit(byte_s1)) begin
							mode_d    = stok_pkg::M_NUM;
							tok_len_d = LEN_ONE;
						end else if (stok_pkg::is_alpha(byte_s1) ||
								byte_s1 == stok_pkg::CH_UNDER) begin
							mode_d    = stok_pkg::M_IDENT;
							tok_len_d = LEN_ONE;
						end else begin
							res[n_res[0]] = stok_pkg::make_token(stok_pkg::K_UNKNOWN,
								FB'(line_q), FB'(col_q), FB'(LEN_ONE));
							n_res = n_res + 2'd1;
						end
					end
				endcase
			end

			// Position tracking, saturating at the counter maximum.
			if (byte_s1 == stok_pkg::CH_LF) begin
				line_d = (line_q == POS_MAX) ? line_q : line_q + POS_ONE;
				col_d  = POS_ONE;
			end else begin
				col_d = (col_q == POS_MAX) ? col_q : col_q + POS_ONE;
			end
		end

		// Mark the final descriptor caused by this byte.
		if (n_res == 2'd2) begin
			res[1].last = 1'b1;
		end else if (n_res == 2'd1) begin
			res[0].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= stok_pkg::M_IDLE;
			line_q     <= POS_ONE;
			col_q      <= POS_ONE;
			tok_line_q <= POS_ONE;
			tok_col_q  <= POS_ONE;
			tok_len_q  <= '0;
			saw_star_q <= 1'b0;
		end else if (process) begin
			mode_q     <= mode_d;
			line_q     <= line_d;
			col_q      <= col_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			tok_len_q  <= tok_len_d;
			saw_star_q <= saw_star_d;
		end
	end

	// ------------------------------------------------------------------
	// Result buffer: up to two writes and one read per cycle.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + (PTR_BITS+1)'(push_cnt) - (PTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= res[0];
		end
		if (push_cnt == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_BITS'(1)] <= res[1];
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {fifo_q[rd_ptr_q].length, fifo_q[rd_ptr_q].column,
		fifo_q[rd_ptr_q].line};
	assign m_tuser  = {3'b000, fifo_q[rd_ptr_q].kind};
	assign m_tlast  = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire
